[rtl/ivwm_pkg.sv]
// Shared constants for the interval voice wavetable mixer: field widths,
// configuration register indexes and the per-voice step reciprocals.
// No dependencies; the top level refers to these by scoped names.
`default_nettype none

package ivwm_pkg;

    // Fixed field widths of the ports.
    localparam int ROOT_W     = 11;
    localparam int SAMPLE_W   = 12;
    localparam int COUNT_W    = 3;
    localparam int MASK_W     = 7;

    // Voices: the root plus six intervals.
    localparam int VOICE_COUNT = 7;
    localparam int VOICE_W     = $clog2(VOICE_COUNT);

    // Defaults for the top-level parameters.
    localparam int TABLE_SIZE_DEF  = 4000;
    localparam int SAMPLE_BITS_DEF = 12;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = MASK_W;
    localparam logic [CFG_IDX_W-1:0] CFG_VOICE_MASK = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAJOR_MODE = 1'b1;

    localparam logic [MASK_W-1:0] MASK_RESET  = 7'h7F;
    localparam logic              MAJOR_RESET = 1'b1;

    // A step is floor(root * num / den). With M = ceil(num * 2^20 / den) the
    // product root * M shifted right by 20 gives that floor exactly for every
    // 11-bit root, because 2^20 exceeds 2047 times the largest denominator.
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = 21;
    localparam int STEP_W      = 12;
    localparam int PROD_W      = ROOT_W + RECIP_W;
    localparam logic [63:0] ONE_S = 64'd1 << RECIP_SHIFT;

    localparam logic [RECIP_W-1:0] MAJ_RECIP [VOICE_COUNT] = '{
        RECIP_W'((ONE_S * 64'd1   + 64'd0)   / 64'd1),
        RECIP_W'((ONE_S * 64'd9   + 64'd7)   / 64'd8),
        RECIP_W'((ONE_S * 64'd81  + 64'd63)  / 64'd64),
        RECIP_W'((ONE_S * 64'd4   + 64'd2)   / 64'd3),
        RECIP_W'((ONE_S * 64'd3   + 64'd1)   / 64'd2),
        RECIP_W'((ONE_S * 64'd27  + 64'd15)  / 64'd16),
        RECIP_W'((ONE_S * 64'd243 + 64'd127) / 64'd128)
    };

    localparam logic [RECIP_W-1:0] MIN_RECIP [VOICE_COUNT] = '{
        RECIP_W'((ONE_S * 64'd1   + 64'd0)   / 64'd1),
        RECIP_W'((ONE_S * 64'd256 + 64'd242) / 64'd243),
        RECIP_W'((ONE_S * 64'd32  + 64'd26)  / 64'd27),
        RECIP_W'((ONE_S * 64'd4   + 64'd2)   / 64'd3),
        RECIP_W'((ONE_S * 64'd3   + 64'd1)   / 64'd2),
        RECIP_W'((ONE_S * 64'd128 + 64'd80)  / 64'd81),
        RECIP_W'((ONE_S * 64'd16  + 64'd8)   / 64'd9)
    };

    // Fixed-point sine constants for building the wavetable.
    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

endpackage

`default_nettype wire

[rtl/interval_voice_wavetable_mixer_unit.sv]
// Top level of the seven-voice just-intonation wavetable mixer: sequencer,
// shared step multiplier, phase registers, raised-sine ROM and divider.
// Depends on ivwm_pkg for widths, register indexes and step reciprocals.
`default_nettype none

//  Channel   Direction  Handshake                    Payload
//  in        in         i_in_valid / o_in_stall      i_root_freq
//  out       out        o_out_valid / i_out_stall    o_sample, o_active_count
//  cfg       in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// For each input beat the sequencer visits every voice in turn: an enabled
// voice takes a fetch and an accumulate state, a disabled voice only a fetch
// (one shared multiplier and one ROM read per voice). Then the bit-serial
// average divider runs (skipped when no voice is active), with setup and
// handoff states before and after it.
// Reset (synchronous, active low) clears all phases and restores the mask and
// mode registers. A finished beat waits in the output register while i_out_stall
// is high; the next input beat is accepted meanwhile.
module interval_voice_wavetable_mixer_unit #(
    parameter int TABLE_SIZE  = ivwm_pkg::TABLE_SIZE_DEF,
    parameter int SAMPLE_BITS = ivwm_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,

    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [ivwm_pkg::ROOT_W-1:0]     i_root_freq,

    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [ivwm_pkg::SAMPLE_W-1:0]        o_sample,
    output logic [ivwm_pkg::COUNT_W-1:0]         o_active_count,

    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [ivwm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ivwm_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int PH_W   = $clog2(TABLE_SIZE);
    localparam int RED_W  = ivwm_pkg::STEP_W + 2;
    localparam int SUM_W  = SAMPLE_BITS + ivwm_pkg::COUNT_W;
    localparam int BIT_W  = $clog2(SAMPLE_BITS);
    localparam int VW     = ivwm_pkg::VOICE_W;
    localparam int CW     = ivwm_pkg::COUNT_W;
    localparam logic [RED_W-1:0] T1_R = RED_W'(TABLE_SIZE);
    localparam logic [RED_W-1:0] T2_R = RED_W'(2 * TABLE_SIZE);
    localparam logic [RED_W-1:0] T4_R = RED_W'(4 * TABLE_SIZE);
    localparam logic [VW-1:0]    LAST_VOICE = VW'(ivwm_pkg::VOICE_COUNT - 1);
    localparam logic [BIT_W-1:0] LAST_BIT   = BIT_W'(SAMPLE_BITS - 1);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_FETCH = 6'b000010,
        ST_ACCUM = 6'b000100,
        ST_PREP  = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_DONE  = 6'b100000
    } t_state;

    // Raised-sine table, built at elaboration from a Q30 Taylor series with
    // truncated products, clamped to one and rounded half up at the end.
    logic [SAMPLE_BITS-1:0] w_wave [TABLE_SIZE];

    for (genvar gi = 0; gi < TABLE_SIZE; gi++) begin : g_wave
        localparam logic [63:0] T64  = 64'(TABLE_SIZE);
        localparam logic [63:0] ONE  = ivwm_pkg::Q30_ONE;
        localparam logic [63:0] Q4   = 64'(gi) * 64'd4;
        localparam logic [63:0] QUAD = Q4 / T64;
        localparam logic [63:0] REM0 = Q4 % T64;
        localparam logic [63:0] REM  = QUAD[0] ? (T64 - REM0) : REM0;
        localparam logic [63:0] ANG  = (REM * ivwm_pkg::Q30_HALF_PI) / T64;
        localparam logic [63:0] A2   = (ANG * ANG) >> 30;
        localparam logic [63:0] TA   = ONE - A2 / 64'd110;
        localparam logic [63:0] TB   = ONE - ((A2 * TA) >> 30) / 64'd72;
        localparam logic [63:0] TC   = ONE - ((A2 * TB) >> 30) / 64'd42;
        localparam logic [63:0] TD   = ONE - ((A2 * TC) >> 30) / 64'd20;
        localparam logic [63:0] TE   = ONE - ((A2 * TD) >> 30) / 64'd6;
        localparam logic [63:0] SR   = (ANG * TE) >> 30;
        localparam logic [63:0] SC   = (SR > ONE) ? ONE : SR;
        localparam logic [63:0] V    = (QUAD >= 64'd2) ? (ONE - SC) : (ONE + SC);
        localparam logic [63:0] MAXC = (64'd1 << SAMPLE_BITS) - 64'd1;
        localparam logic [63:0] ENT  = (V * MAXC + (64'd1 << 30)) >> 31;
        assign w_wave[gi] = SAMPLE_BITS'(ENT);
    end

    t_state                          r_state;
    logic [ivwm_pkg::MASK_W-1:0]     r_mask;
    logic                            r_major;
    logic [PH_W-1:0]                 r_phase [ivwm_pkg::VOICE_COUNT];
    logic [VW-1:0]                   r_voice;
    logic [CW-1:0]                   r_count;
    logic [BIT_W-1:0]                r_bit;
    logic [ivwm_pkg::ROOT_W-1:0]     r_root;
    logic [SUM_W-1:0]                r_sum;
    logic [SAMPLE_BITS-1:0]          r_wave_q;
    logic [ivwm_pkg::STEP_W-1:0]     r_step;
    logic [CW-1:0]                   r_rem;
    logic [SAMPLE_BITS-1:0]          r_num;
    logic                            r_out_valid;
    logic [ivwm_pkg::SAMPLE_W-1:0]   r_out_sample;
    logic [CW-1:0]                   r_out_count;

    logic                            w_active;
    logic [ivwm_pkg::RECIP_W-1:0]    w_recip;
    logic [ivwm_pkg::PROD_W-1:0]     w_prod;
    logic [RED_W-1:0]                w_red0;
    logic [RED_W-1:0]                w_red1;
    logic [RED_W-1:0]                w_red2;
    logic [RED_W-1:0]                w_red3;
    logic [PH_W-1:0]                 n_phase;
    logic [SUM_W-1:0]                w_dividend;
    logic [CW:0]                     w_trial;
    logic                            w_ge;
    logic                            w_out_free;

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_sample       = r_out_sample;
    assign o_active_count = r_out_count;

    assign w_active = (r_root != '0) && r_mask[r_voice];
    assign w_recip  = r_major ? ivwm_pkg::MAJ_RECIP[r_voice] : ivwm_pkg::MIN_RECIP[r_voice];
    assign w_prod   = ivwm_pkg::PROD_W'(r_root) * ivwm_pkg::PROD_W'(w_recip);

    // The sum of a phase and a step stays below 8 * TABLE_SIZE, so three
    // conditional subtractions reduce it modulo the table size.
    always_comb begin
        w_red0 = RED_W'(r_phase[r_voice]) + RED_W'(r_step);
        w_red1 = (w_red0 >= T4_R) ? (w_red0 - T4_R) : w_red0;
        w_red2 = (w_red1 >= T2_R) ? (w_red1 - T2_R) : w_red1;
        w_red3 = (w_red2 >= T1_R) ? (w_red2 - T1_R) : w_red2;
        n_phase = PH_W'(w_red3);
    end

    // Rounded average: (sum + count/2) / count, one quotient bit per cycle.
    assign w_dividend = r_sum + SUM_W'(r_count >> 1);
    assign w_trial    = {r_rem, r_num[SAMPLE_BITS-1]};
    assign w_ge       = (w_trial >= {1'b0, r_count});
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= ivwm_pkg::MASK_RESET;
            r_major <= ivwm_pkg::MAJOR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ivwm_pkg::CFG_VOICE_MASK: r_mask  <= i_cfg_data;
                ivwm_pkg::CFG_MAJOR_MODE: r_major <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < ivwm_pkg::VOICE_COUNT; v++) begin
                r_phase[v] <= '0;
            end
        end else if (r_state == ST_ACCUM) begin
            r_phase[r_voice] <= n_phase;
        end
    end

    // Sequencer and control counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_voice     <= '0;
            r_count     <= '0;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == ST_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_voice <= '0;
                        r_count <= '0;
                        r_state <= ST_FETCH;
                    end
                end
                ST_FETCH: begin
                    if (w_active) begin
                        r_state <= ST_ACCUM;
                    end else if (r_voice == LAST_VOICE) begin
                        r_state <= ST_PREP;
                    end else begin
                        r_voice <= r_voice + VW'(1);
                    end
                end
                ST_ACCUM: begin
                    r_count <= r_count + CW'(1);
                    if (r_voice == LAST_VOICE) begin
                        r_state <= ST_PREP;
                    end else begin
                        r_voice <= r_voice + VW'(1);
                        r_state <= ST_FETCH;
                    end
                end
                ST_PREP: begin
                    r_bit   <= '0;
                    r_state <= (r_count == '0) ? ST_DONE : ST_DIV;
                end
                ST_DIV: begin
                    r_bit <= r_bit + BIT_W'(1);
                    if (r_bit == LAST_BIT) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    r_root <= i_root_freq;
                    r_sum  <= '0;
                end
            end
            ST_FETCH: begin
                r_wave_q <= w_wave[r_phase[r_voice]];
                r_step   <= w_prod[ivwm_pkg::RECIP_SHIFT +: ivwm_pkg::STEP_W];
            end
            ST_ACCUM: begin
                r_sum <= r_sum + SUM_W'(r_wave_q);
            end
            ST_PREP: begin
                // With no active voice the quotient register stays zero.
                r_rem <= (r_count == '0) ? '0 : w_dividend[SUM_W-1 -: CW];
                r_num <= (r_count == '0) ? '0 : w_dividend[SAMPLE_BITS-1:0];
            end
            ST_DIV: begin
                r_rem <= w_ge ? CW'(w_trial - {1'b0, r_count}) : w_trial[CW-1:0];
                r_num <= {r_num[SAMPLE_BITS-2:0], w_ge};
            end
            ST_DONE: begin
                if (w_out_free) begin
                    r_out_sample <= ivwm_pkg::SAMPLE_W'(r_num);
                    r_out_count  <= r_count;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// Self-checking bench for the seven-voice interval wavetable mixer: an in-bench
// model of the phases and raised-sine table predicts every sample it mixes.
// Depends on ivwm_pkg and interval_voice_wavetable_mixer_unit.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TSIZE       = ivwm_pkg::TABLE_SIZE_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int N_PHASES    = 12;
    localparam int NV          = ivwm_pkg::VOICE_COUNT;
    localparam int RW          = ivwm_pkg::ROOT_W;
    localparam int SW          = ivwm_pkg::SAMPLE_W;
    localparam int CNW         = ivwm_pkg::COUNT_W;
    localparam int MW          = ivwm_pkg::MASK_W;
    localparam int IW          = ivwm_pkg::CFG_IDX_W;
    localparam int DW          = ivwm_pkg::CFG_DATA_W;

    // Just-intonation ratios, voice 0 is the root itself.
    localparam bit [63:0] MAJ_NUM [NV] = '{1, 9, 81, 4, 3, 27, 243};
    localparam bit [63:0] MAJ_DEN [NV] = '{1, 8, 64, 3, 2, 16, 128};
    localparam bit [63:0] MIN_NUM [NV] = '{1, 256, 32, 4, 3, 128, 16};
    localparam bit [63:0] MIN_DEN [NV] = '{1, 243, 27, 3, 2, 81, 9};

    localparam bit [RW-1:0] DIRECTED_ROOTS [14] = '{
        0, 1, 2, 2000, 2047, 2001, 1024, 1023, 1365, 682, 0, 3, 243, 1999
    };

    typedef struct packed {
        logic [SW-1:0]  sample;
        logic [CNW-1:0] count;
    } t_mix;

    typedef enum int {STALL_NONE, STALL_SPARSE, STALL_BURST, STALL_HEAVY} t_stall_style;

    class t_mix_scoreboard;
        bit [SW-1:0]     wave [TSIZE];
        bit [11:0]       voice_phase [NV];
        bit [MW-1:0]     voice_mask;
        bit              major;
        t_mix            pending_samples [$];
        int              errors;
        int              n_roots;
        int              n_samples;
        int              n_silent;
        int              n_high_roots;

        function new();
            build_wave();
            foreach (voice_phase[v]) voice_phase[v] = '0;
            voice_mask = ivwm_pkg::MASK_RESET;
            major = ivwm_pkg::MAJOR_RESET;
        endfunction

        // Q30 Taylor sine for an angle in the first quadrant.
        function bit [63:0] sine_q30(bit [63:0] a);
            bit [63:0] a2;
            bit [63:0] t;
            a2 = (a * a) >> 30;
            t = ivwm_pkg::Q30_ONE - a2 / 64'd110;
            t = ivwm_pkg::Q30_ONE - ((a2 * t) >> 30) / 64'd72;
            t = ivwm_pkg::Q30_ONE - ((a2 * t) >> 30) / 64'd42;
            t = ivwm_pkg::Q30_ONE - ((a2 * t) >> 30) / 64'd20;
            t = ivwm_pkg::Q30_ONE - ((a2 * t) >> 30) / 64'd6;
            t = (a * t) >> 30;
            if (t > ivwm_pkg::Q30_ONE) t = ivwm_pkg::Q30_ONE;
            return t;
        endfunction

        function void build_wave();
            bit [63:0] q4;
            bit [63:0] quad;
            bit [63:0] rem;
            bit [63:0] s;
            bit [63:0] v;
            bit [63:0] maxcode;
            maxcode = (64'd1 << ivwm_pkg::SAMPLE_BITS_DEF) - 64'd1;
            for (int i = 0; i < TSIZE; i++) begin
                q4 = 64'd4 * 64'(i);
                quad = q4 / 64'(TSIZE);
                rem = q4 % 64'(TSIZE);
                if (quad[0]) rem = 64'(TSIZE) - rem;
                s = sine_q30((rem * ivwm_pkg::Q30_HALF_PI) / 64'(TSIZE));
                v = (quad >= 64'd2) ? (ivwm_pkg::Q30_ONE - s) : (ivwm_pkg::Q30_ONE + s);
                wave[i] = SW'((v * maxcode + (64'd1 << 30)) >> 31);
            end
        endfunction

        function void set_reg(logic [IW-1:0] idx, logic [DW-1:0] value);
            case (idx)
                ivwm_pkg::CFG_VOICE_MASK: voice_mask = value[MW-1:0];
                ivwm_pkg::CFG_MAJOR_MODE: major = value[0];
                default: ;
            endcase
        endfunction

        // Advance every active voice by one tick and queue the mixed sample.
        function void note_tick(logic [RW-1:0] root);
            bit [63:0] root64;
            bit [63:0] sum;
            bit [63:0] stp;
            bit [63:0] ph;
            bit [63:0] cnt;
            t_mix      r;
            root64 = 64'(root);
            sum = 0;
            cnt = 0;
            n_roots++;
            if (root > 2000) n_high_roots++;
            for (int v = 0; v < NV; v++) begin
                if (root64 != 0 && voice_mask[v]) begin
                    stp = major ? (root64 * MAJ_NUM[v]) / MAJ_DEN[v]
                                : (root64 * MIN_NUM[v]) / MIN_DEN[v];
                    ph = 64'(voice_phase[v]) % 64'(TSIZE);
                    sum += 64'(wave[ph]);
                    cnt++;
                    voice_phase[v] = 12'((ph + stp) % 64'(TSIZE));
                end
            end
            r.sample = (cnt != 0) ? SW'((sum + cnt / 2) / cnt) : '0;
            r.count = CNW'(cnt);
            if (cnt == 0) n_silent++;
            pending_samples.push_back(r);
        endfunction

        function int pending();
            return pending_samples.size();
        endfunction

        task report(string what);
            if (errors < 30) $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        task check_result(logic [SW-1:0] smp, logic [CNW-1:0] cnt);
            t_mix want;
            n_samples++;
            if (pending_samples.size() == 0) begin
                report($sformatf("sample %0d count %0d with nothing outstanding", smp, cnt));
                return;
            end
            want = pending_samples.pop_front();
            if (smp !== want.sample)
                report($sformatf("sample %0d, wanted %0d", smp, want.sample));
            if (cnt !== want.count)
                report($sformatf("active count %0d, wanted %0d", cnt, want.count));
        endtask
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [RW-1:0]     i_root_freq = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [SW-1:0]     o_sample;
    logic [CNW-1:0]    o_active_count;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [IW-1:0]     i_cfg_index = '0;
    logic [DW-1:0]     i_cfg_data = '0;

    t_mix_scoreboard sb = new();
    int              cycles = 0;
    int              stall_tick = 0;
    t_stall_style    stall_style = STALL_NONE;

    interval_voice_wavetable_mixer_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_root_freq    (i_root_freq),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_sample       (o_sample),
        .o_active_count (o_active_count),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d samples outstanding", cycles, sb.pending());
            $display("simulation failed");
            $finish;
        end
    end

    // The receiver switches at random between stall styles.
    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 1;
        if (stall_tick % 256 == 0) stall_style <= t_stall_style'($urandom_range(0, 3));
        case (stall_style)
            STALL_NONE:   i_out_stall <= 1'b0;
            STALL_SPARSE: i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_BURST:  i_out_stall <= ((stall_tick / 8) % 4 == 3);
            default:      i_out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_sample, o_active_count);
    end

    // Leaves i_in_valid high on return so that the next beat can follow directly.
    task automatic send_root(input logic [RW-1:0] root);
        i_in_valid <= 1'b1;
        i_root_freq <= root;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_tick(root);
    endtask

    task automatic write_reg(input logic [IW-1:0] idx, input logic [DW-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, value);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    function automatic logic [RW-1:0] pick_root();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 4) return '0;
        if (sel < 8) return RW'($urandom_range(2001, 2047));
        if (sel < 12) return RW'($urandom_range(1, 4));
        if (sel < 16) return RW'(2000);
        return RW'($urandom_range(1, 2000));
    endfunction

    // Bursts of back-to-back beats separated by random idle gaps.
    task automatic play_random(input int n_items);
        int left;
        int burst;
        int gap;
        left = n_items;
        while (left > 0) begin
            burst = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            for (int k = 0; k < burst && left > 0; k++) begin
                send_root(pick_root());
                left--;
            end
        end
    endtask

    initial begin
        bit [MW-1:0] phase_mask [N_PHASES];
        bit          phase_major [N_PHASES];
        phase_mask[0] = 7'h7F;  phase_major[0] = 1'b0;
        phase_mask[1] = 7'h00;  phase_major[1] = 1'b1;
        phase_mask[2] = 7'h01;  phase_major[2] = 1'b1;
        phase_mask[3] = 7'h40;  phase_major[3] = 1'b0;
        phase_mask[4] = 7'h55;  phase_major[4] = 1'b1;
        phase_mask[5] = 7'h2A;  phase_major[5] = 1'b0;
        phase_mask[6] = 7'h7F;  phase_major[6] = 1'b1;
        for (int p = 7; p < N_PHASES; p++) begin
            phase_mask[p] = MW'($urandom_range(0, 127));
            phase_major[p] = 1'($urandom_range(0, 1));
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values first: every voice on, major ratios.
        foreach (DIRECTED_ROOTS[k]) send_root(DIRECTED_ROOTS[k]);
        drain();

        for (int p = 0; p < N_PHASES; p++) begin
            write_reg(ivwm_pkg::CFG_VOICE_MASK, DW'(phase_mask[p]));
            // Upper data bits of the mode register are junk and must be ignored.
            write_reg(ivwm_pkg::CFG_MAJOR_MODE,
                      {(DW-1)'($urandom_range(0, 63)), phase_major[p]});
            i_cfg_valid <= 1'b0;
            play_random((phase_mask[p] == 0) ? 40 : 150);
            drain();
        end

        repeat (40) @(posedge i_clk);
        if (sb.pending() != 0) sb.report($sformatf("%0d samples never arrived", sb.pending()));
        $display("%0d root ticks over %0d register settings, %0d silent, %0d roots above 2000",
                 sb.n_roots, N_PHASES + 1, sb.n_silent, sb.n_high_roots);
        $display("%0d samples compared, %0d mismatches", sb.n_samples, sb.errors);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
